// ----- sv/egcd_pkg.sv -----
// ----------------------------------------------------------------------------
// egcd_pkg: shared types for the extended GCD block
// Controller state encoding and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package egcd_pkg;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FINISH = 4'b1000
    } egcd_state_t;

    typedef struct packed {
        logic load;    // take a new request into the working registers
        logic step;    // one bit of the serial division
        logic update;  // advance the remainder and coefficient sequence
        logic finish;  // move the answer into the output register
    } egcd_cmd_t;

    typedef struct packed {
        logic div_last;  // current division bit is the last one
        logic rem_zero;  // remainder of the finished division is zero
        logic b_zero;    // incoming second operand is zero
    } egcd_status_t;

endpackage

// ----- sv/egcd_if.sv -----
// ----------------------------------------------------------------------------
// egcd channel interfaces
// Valid/ready channels for the operand requests and the GCD results.
// ----------------------------------------------------------------------------
interface egcd_in_if #(
    parameter int W = 31
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] operand_a;
    logic [W-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_out_if #(
    parameter int W = 31
) ();
    logic                valid;
    logic                ready;
    logic [W-1:0]        gcd_value;
    logic signed [W:0]   coef_a;
    logic signed [W:0]   coef_b;

    modport source (output valid, output gcd_value, output coef_a, output coef_b,
                    input ready);
    modport sink   (input valid, input gcd_value, input coef_a, input coef_b,
                    output ready);
endinterface

// ----- sv/extended_gcd_bezout.sv -----
// ----------------------------------------------------------------------------
// extended_gcd_bezout: greatest common divisor with Bezout coefficients
// Extended Euclid over OPERAND_WIDTH-bit unsigned operands.
// ----------------------------------------------------------------------------
// Each request (operand_a, operand_b) yields one result gcd_value with
// coef_a, coef_b such that operand_a*coef_a + operand_b*coef_b = gcd_value;
// a zero operand_b gives (operand_a, 1, 0). One request is worked on at a
// time. Each request takes k Euclid divisions (up to about 46 for 31-bit
// operands); each division is done by the serial divider, which produces
// one quotient bit per cycle, and is followed by an update step. A finished
// result waits in an output register, and the next request is taken while
// it waits.
module extended_gcd_bezout #(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    egcd_in_if.sink    operands,
    egcd_out_if.source result
);
    import egcd_pkg::*;

    egcd_cmd_t    cmd;
    egcd_status_t status;

    egcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    egcd_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .status    (status),
        .operand_a (operands.operand_a),
        .operand_b (operands.operand_b),
        .gcd_value (result.gcd_value),
        .coef_a    (result.coef_a),
        .coef_b    (result.coef_b)
    );

endmodule

// ----- sv/egcd_datapath.sv -----
// ----------------------------------------------------------------------------
// egcd_datapath: remainder and coefficient registers
// Restoring division one quotient bit per cycle; the products q*s1 and q*t1
// are built alongside by shift-and-add, so the update needs only subtracts.
// ----------------------------------------------------------------------------
module egcd_datapath #(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic                          clk,
    input  egcd_pkg::egcd_cmd_t           cmd,
    output egcd_pkg::egcd_status_t        status,
    input  logic [OPERAND_WIDTH-1:0]      operand_a,
    input  logic [OPERAND_WIDTH-1:0]      operand_b,
    output logic [OPERAND_WIDTH-1:0]      gcd_value,
    output logic signed [OPERAND_WIDTH:0] coef_a,
    output logic signed [OPERAND_WIDTH:0] coef_b
);
    import egcd_pkg::*;

    localparam int W        = OPERAND_WIDTH;
    localparam int C        = OPERAND_WIDTH + 1;
    localparam int CNT_W    = $clog2(OPERAND_WIDTH);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(OPERAND_WIDTH - 1);

    logic [W-1:0]     r0_reg, r0_next, r1_reg, r1_next;
    logic [W-1:0]     rem_reg, rem_next, dvd_reg, dvd_next;
    logic [C-1:0]     s0_reg, s0_next, s1_reg, s1_next;
    logic [C-1:0]     t0_reg, t0_next, t1_reg, t1_next;
    logic [C-1:0]     ps_reg, ps_next, pt_reg, pt_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     gcd_reg;
    logic [C-1:0]     ca_reg, cb_reg;

    logic [W:0]       shifted, divisor_ext, diff;
    logic             qbit;
    logic [W-1:0]     rem_step;
    logic [C-1:0]     ps_step, pt_step;

    always_comb
    begin
        shifted     = {rem_reg, dvd_reg[W-1]};
        divisor_ext = {1'b0, r1_reg};
        qbit        = (shifted >= divisor_ext);
        diff        = shifted - divisor_ext;
        rem_step    = qbit ? diff[W-1:0] : shifted[W-1:0];
        ps_step     = {ps_reg[C-2:0], 1'b0} + (qbit ? s1_reg : {C{1'b0}});
        pt_step     = {pt_reg[C-2:0], 1'b0} + (qbit ? t1_reg : {C{1'b0}});
    end

    always_comb
    begin
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        t0_next  = t0_reg;
        t1_next  = t1_reg;
        ps_next  = ps_reg;
        pt_next  = pt_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            r0_next  = operand_a;
            r1_next  = operand_b;
            s0_next  = C'(1);
            s1_next  = '0;
            t0_next  = '0;
            t1_next  = C'(1);
            rem_next = '0;
            dvd_next = operand_a;
            ps_next  = '0;
            pt_next  = '0;
            cnt_next = CNT_INIT;
        end
        else if (cmd.step)
        begin
            rem_next = rem_step;
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            ps_next  = ps_step;
            pt_next  = pt_step;
            cnt_next = cnt_reg - 1'b1;
        end
        else if (cmd.update)
        begin
            // shift the sequence down one place and divide the old r1 next
            r0_next  = r1_reg;
            r1_next  = rem_reg;
            s0_next  = s1_reg;
            s1_next  = s0_reg - ps_reg;
            t0_next  = t1_reg;
            t1_next  = t0_reg - pt_reg;
            rem_next = '0;
            dvd_next = r1_reg;
            ps_next  = '0;
            pt_next  = '0;
            cnt_next = CNT_INIT;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        s0_reg  <= s0_next;
        s1_reg  <= s1_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        ps_reg  <= ps_next;
        pt_reg  <= pt_next;
        cnt_reg <= cnt_next;
    end

    // a zero second operand leaves r1 at zero: answer with (r0, 1, 0)
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (r1_reg == '0)
            begin
                gcd_reg <= r0_reg;
                ca_reg  <= s0_reg;
                cb_reg  <= t0_reg;
            end
            else
            begin
                gcd_reg <= r1_reg;
                ca_reg  <= s1_reg;
                cb_reg  <= t1_reg;
            end
        end
    end

    assign status.div_last = (cnt_reg == '0);
    assign status.rem_zero = (rem_reg == '0);
    assign status.b_zero   = (operand_b == '0);

    assign gcd_value = gcd_reg;
    assign coef_a    = $signed(ca_reg);
    assign coef_b    = $signed(cb_reg);

endmodule

// ----- sv/egcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// egcd_ctrl: sequencing of the Euclid steps
// Runs divide/update rounds until the remainder is zero and owns the
// handshake on both channels.
// ----------------------------------------------------------------------------
module egcd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  egcd_pkg::egcd_status_t status,
    output egcd_pkg::egcd_cmd_t    cmd
);
    import egcd_pkg::*;

    egcd_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        in_acc, out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign cmd.load   = in_acc;
    assign cmd.step   = (state_reg == ST_DIV);
    assign cmd.update = (state_reg == ST_UPDATE) && !status.rem_zero;
    assign cmd.finish = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = status.b_zero ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = status.rem_zero ? ST_FINISH : ST_DIV;
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.finish || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- sv/egcd_checker.sv -----
// ----------------------------------------------------------------------------
// egcd_checker: port-level checks for extended_gcd_bezout
// Watches both channels and the shape of the results over time.
// ----------------------------------------------------------------------------
module egcd_checker #(
    parameter int OPERAND_WIDTH = 31
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [OPERAND_WIDTH-1:0]      gcd_value,
    input logic signed [OPERAND_WIDTH:0] coef_a,
    input logic signed [OPERAND_WIDTH:0] coef_b
);
    logic [1:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // count requests taken whose result is not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
            pending_next = pending_reg + 2'd1;
        else if (out_acc && !in_acc)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 2'd0;
        else
            pending_reg <= pending_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without a pending request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg <= 2'd1)
        else $error("request taken with two already in flight");

    a_zero_coef: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (coef_a == '0) |-> (coef_b == 'sd1) && (gcd_value != '0))
        else $error("zero coef_a without coef_b of one");

    a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (gcd_value == '0) |-> (coef_a == 'sd1) && (coef_b == '0))
        else $error("zero gcd without coefficients (1, 0)");

endmodule

bind extended_gcd_bezout egcd_checker #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
) u_egcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .gcd_value (result.gcd_value),
    .coef_a    (result.coef_a),
    .coef_b    (result.coef_b)
);
